/* design/lcr_pkg.sv */
// shared types and constants for the load cell converter serial reader
package lcr_pkg;

  // converter word size and datapath widths
  localparam int SAMPLE_BITS = 24;
  localparam int BIT_CNT_W   = $clog2(SAMPLE_BITS + 1);
  localparam int TIMEOUT_W   = 20;
  localparam int COUNT_W     = 8;
  localparam int SUM_W       = 32;
  localparam int VALUE_W     = 24;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 1;
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_READY_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT = 1'd1;

  // configuration reset values
  localparam logic [TIMEOUT_W-1:0] READY_TIMEOUT_RST = 20'd200000;
  localparam logic [COUNT_W-1:0]   AVERAGE_COUNT_RST = 8'd1;

  // one tick word as it travels from the front queue to the sequencer
  typedef struct packed {
    logic read_request;
    logic data_level;
  } lcr_item_t;

  // request to the serial divider
  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } lcr_div_req_t;

  // answer from the serial divider
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
  } lcr_div_rsp_t;

endpackage

/* design/load_cell_adc_serial_reader_core.sv */
// top level of the load cell converter serial reader
//
//   channel  signals                                   direction
//   in       in_valid_i, in_stall_o, read_request_i,   word in
//            data_level_i
//   out      out_valid_o, out_stall_i, result fields   word out
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i         register write
//
// each in word gives exactly one out word; an ordinary tick is stepped by the
// sequencer alone, a tick that closes an average also waits for the serial
// divider, one bit a cycle over the 32-bit sum, and no new word is taken meanwhile
// a two-entry queue keeps taking words while the out word is stalled, until it is full
// reset is asynchronous and active low and clears all control state
module load_cell_adc_serial_reader_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               read_request_i,
  input  logic                               data_level_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               clock_level_o,
  output logic                               busy_res_o,
  output logic                               reading_valid_o,
  output logic signed [lcr_pkg::VALUE_W-1:0] reading_value_o,
  output logic                               average_valid_o,
  output logic signed [lcr_pkg::VALUE_W-1:0] average_value_o,
  output logic                               timed_out_o
);

  logic                  item_valid;
  lcr_pkg::lcr_item_t    item;
  logic                  item_pop;
  lcr_pkg::lcr_div_req_t div_req;
  lcr_pkg::lcr_div_rsp_t div_rsp;

  // word queue
  lcr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .read_request_i (read_request_i),
    .data_level_i   (data_level_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  // average divider
  lcr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // protocol sequencer
  lcr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_pop_o      (item_pop),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .clock_level_o   (clock_level_o),
    .busy_res_o      (busy_res_o),
    .reading_valid_o (reading_valid_o),
    .reading_value_o (reading_value_o),
    .average_valid_o (average_valid_o),
    .average_value_o (average_value_o),
    .timed_out_o     (timed_out_o)
  );

endmodule

/* design/lcr_front.sv */
// front queue: accepts tick words and hands them to the sequencer
module lcr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              read_request_i,
  input  logic              data_level_i,
  output logic              item_valid_o,
  output lcr_pkg::lcr_item_t item_o,
  input  logic              item_pop_i
);

  lcr_pkg::lcr_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  // handshake on both sides
  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{read_request: read_request_i, data_level: data_level_i};
    end
  end

  // fill count never exceeds the two entries
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("front queue count out of range");

endmodule

/* design/lcr_div.sv */
// serial signed divider, one quotient bit per cycle, truncating toward zero
module lcr_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcr_pkg::lcr_div_req_t req_i,
  output lcr_pkg::lcr_div_rsp_t rsp_o
);

  logic [lcr_pkg::SUM_W-1:0]     quo_q, quo_d;
  logic [lcr_pkg::COUNT_W-1:0]   rem_q, rem_d;
  logic [lcr_pkg::COUNT_W-1:0]   dvs_q;
  logic [lcr_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          neg_q;
  logic                          busy_q;
  logic                          done_q;
  logic [lcr_pkg::COUNT_W:0]     trial;
  logic                          ge;
  logic [lcr_pkg::COUNT_W:0]     diff;
  logic [lcr_pkg::SUM_W-1:0]     result;

  // restoring step
  always_comb begin
    trial = {rem_q, quo_q[lcr_pkg::SUM_W-1]};
    ge    = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
    rem_d = ge ? diff[lcr_pkg::COUNT_W-1:0] : trial[lcr_pkg::COUNT_W-1:0];
    quo_d = {quo_q[lcr_pkg::SUM_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == lcr_pkg::DIV_CNT_W'(lcr_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitude in, quotient shifts in from the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[lcr_pkg::SUM_W-1];
      quo_q <= req_i.dividend[lcr_pkg::SUM_W-1] ? (~req_i.dividend + 1'b1)
                                                : req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // apply the sign to the magnitude quotient
  assign result         = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = result[lcr_pkg::VALUE_W-1:0];

  // no new start lands on a division in flight
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start)
    else $error("divider started while busy");

  // done follows the last step of a running division
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

/* design/lcr_back.sv */
// back sequencer: steps the converter protocol one tick word at a time
module lcr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               item_valid_i,
  input  lcr_pkg::lcr_item_t                 item_i,
  output logic                               item_pop_o,
  output lcr_pkg::lcr_div_req_t              div_req_o,
  input  lcr_pkg::lcr_div_rsp_t              div_rsp_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               clock_level_o,
  output logic                               busy_res_o,
  output logic                               reading_valid_o,
  output logic signed [lcr_pkg::VALUE_W-1:0] reading_value_o,
  output logic                               average_valid_o,
  output logic signed [lcr_pkg::VALUE_W-1:0] average_value_o,
  output logic                               timed_out_o
);

  // protocol phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_WAIT      = 3'd1;
  localparam logic [2:0] PH_HIGH      = 3'd2;
  localparam logic [2:0] PH_LOW       = 3'd3;
  localparam logic [2:0] PH_GAIN_HIGH = 3'd4;
  localparam logic [2:0] PH_GAIN_LOW  = 3'd5;

  // sequencer states
  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  localparam int SB = lcr_pkg::SAMPLE_BITS;

  logic [lcr_pkg::TIMEOUT_W-1:0] timeout_q;
  logic [lcr_pkg::COUNT_W-1:0]   avg_cnt_q;

  logic [2:0]                    phase_q, phase_d, phase_x;
  logic [lcr_pkg::TIMEOUT_W-1:0] wait_q, wait_d, wait_x;
  logic [lcr_pkg::BIT_CNT_W-1:0] bit_q, bit_d;
  logic [SB-1:0]                 shift_q, shift_d;
  logic [lcr_pkg::SUM_W-1:0]     sum_q, sum_d, sum_x;
  logic [lcr_pkg::COUNT_W-1:0]   rd_q, rd_d, rd_x;
  logic                          tos_q, tos_d, tos_x;
  logic                          st_q, st_d;
  logic                          out_valid_q, out_valid_d;

  logic                          started;
  logic                          clk_lvl;
  logic                          fin;
  logic                          avg_fin;
  logic [lcr_pkg::SUM_W-1:0]     reading;
  logic [lcr_pkg::COUNT_W-1:0]   cnt_eff;
  logic                          out_free;
  logic                          pop;

  // output payload registers
  logic                          clk_lvl_q;
  logic                          busy_q;
  logic                          rvalid_q;
  logic [lcr_pkg::VALUE_W-1:0]   rvalue_q;
  logic                          avalid_q;
  logic [lcr_pkg::VALUE_W-1:0]   avalue_q;
  logic                          tout_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= lcr_pkg::READY_TIMEOUT_RST;
      avg_cnt_q <= lcr_pkg::AVERAGE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcr_pkg::CFG_READY_TIMEOUT: timeout_q <= cfg_data_i[lcr_pkg::TIMEOUT_W-1:0];
        lcr_pkg::CFG_AVERAGE_COUNT: avg_cnt_q <= cfg_data_i[lcr_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // take a word when running and the output slot is free or draining
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = (st_q == ST_RUN) && item_valid_i && out_free;
  assign item_pop_o = pop;
  assign cnt_eff    = (avg_cnt_q == '0) ? lcr_pkg::COUNT_W'(1) : avg_cnt_q;

  // one protocol tick
  always_comb begin
    started = (phase_q == PH_IDLE) && item_i.read_request;
    phase_x = started ? PH_WAIT : phase_q;
    wait_x  = started ? '0 : wait_q;
    sum_x   = started ? '0 : sum_q;
    rd_x    = started ? '0 : rd_q;
    tos_x   = started ? 1'b0 : tos_q;

    phase_d = phase_x;
    wait_d  = wait_x;
    bit_d   = bit_q;
    shift_d = shift_q;
    sum_d   = sum_x;
    rd_d    = rd_x;
    tos_d   = tos_x;
    clk_lvl = 1'b0;
    fin     = 1'b0;
    avg_fin = 1'b0;
    reading = '0;

    case (phase_x)
      PH_WAIT: begin
        if (!item_i.data_level) begin
          bit_d   = '0;
          shift_d = '0;
          clk_lvl = 1'b1;
          phase_d = PH_HIGH;
        end else if (wait_x >= timeout_q) begin
          tos_d = 1'b1;
          fin   = 1'b1;
        end else begin
          wait_d = wait_x + 1'b1;
        end
      end
      PH_HIGH: begin
        shift_d = {shift_q[SB-2:0], item_i.data_level};
        bit_d   = bit_q + 1'b1;
        phase_d = PH_LOW;
      end
      PH_LOW: begin
        clk_lvl = 1'b1;
        phase_d = (bit_q >= lcr_pkg::BIT_CNT_W'(SB)) ? PH_GAIN_HIGH : PH_HIGH;
      end
      PH_GAIN_HIGH: begin
        phase_d = PH_GAIN_LOW;
      end
      PH_GAIN_LOW: begin
        reading = lcr_pkg::SUM_W'(signed'(shift_q));
        fin     = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // reading finished: accumulate and check the average count
    if (fin) begin
      rd_d    = rd_x + 1'b1;
      sum_d   = sum_x + reading;
      wait_d  = '0;
      avg_fin = (rd_d >= cnt_eff);
      phase_d = avg_fin ? PH_IDLE : PH_WAIT;
    end
  end

  // sequencer state and output valid
  always_comb begin
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (st_q)
      ST_RUN: begin
        if (pop) begin
          if (avg_fin) begin
            st_d = ST_DIV;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          st_d        = ST_RUN;
          out_valid_d = 1'b1;
        end
      end
      default: st_d = ST_RUN;
    endcase
  end

  assign div_req_o.start    = pop && avg_fin;
  assign div_req_o.dividend = sum_d;
  assign div_req_o.divisor  = cnt_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      wait_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      sum_q       <= '0;
      rd_q        <= '0;
      tos_q       <= 1'b0;
      st_q        <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if (pop) begin
        phase_q <= phase_d;
        wait_q  <= wait_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        sum_q   <= sum_d;
        rd_q    <= rd_d;
        tos_q   <= tos_d;
      end
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      clk_lvl_q <= clk_lvl;
      busy_q    <= (phase_d != PH_IDLE);
      rvalid_q  <= fin;
      rvalue_q  <= reading[lcr_pkg::VALUE_W-1:0];
      avalid_q  <= avg_fin;
      avalue_q  <= '0;
      tout_q    <= tos_d;
    end else if ((st_q == ST_DIV) && div_rsp_i.done) begin
      avalue_q <= div_rsp_i.quotient;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign clock_level_o   = clk_lvl_q;
  assign busy_res_o      = busy_q;
  assign reading_valid_o = rvalid_q;
  assign reading_value_o = signed'(rvalue_q);
  assign average_valid_o = avalid_q;
  assign average_value_o = signed'(avalue_q);
  assign timed_out_o     = tout_q;

  // an averaged word always closes a reading and ends the busy period
  a_avg_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && avalid_q) |-> (rvalid_q && !busy_q))
    else $error("average word without a finished reading");

  // nothing is presented while the divider works on the pending word
  a_div_hides_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> !out_valid_q)
    else $error("output valid during division");

  // a division is entered only from a word that closed an average
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q) |-> $past(pop))
    else $error("division entered without a popped word");

endmodule

/* sim/load_cell_adc_serial_reader_core_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the load cell converter serial reader core
module load_cell_adc_serial_reader_core_tb;

  localparam int IDLE_PCT     = 36;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 40;
  localparam int REPORT_MAX   = 10;
  localparam int TICK_TARGET  = 650;

  // sequencer phases of the serial read
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT_READY,
    ST_CLK_HIGH,
    ST_CLK_LOW,
    ST_GAIN_HIGH,
    ST_GAIN_LOW
  } seq_state_e;

  // one result word, in port order
  typedef struct packed {
    logic                        sclk;
    logic                        busy;
    logic                        rd_vld;
    logic [lcr_pkg::VALUE_W-1:0] rd_val;
    logic                        avg_vld;
    logic [lcr_pkg::VALUE_W-1:0] avg_val;
    logic                        tmo;
  } tick_out_t;

  logic                               clk_i          = 1'b0;
  logic                               rst_ni         = 1'b0;
  logic                               cfg_we_i       = 1'b0;
  logic [lcr_pkg::CFG_IDX_W-1:0]      cfg_index_i    = '0;
  logic [lcr_pkg::CFG_DATA_W-1:0]     cfg_data_i     = '0;
  logic                               in_valid_i     = 1'b0;
  logic                               in_stall_o;
  logic                               read_request_i = 1'b0;
  logic                               data_level_i   = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i    = 1'b0;
  logic                               clock_level_o;
  logic                               busy_res_o;
  logic                               reading_valid_o;
  logic signed [lcr_pkg::VALUE_W-1:0] reading_value_o;
  logic                               average_valid_o;
  logic signed [lcr_pkg::VALUE_W-1:0] average_value_o;
  logic                               timed_out_o;

  load_cell_adc_serial_reader_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .read_request_i  (read_request_i),
    .data_level_i    (data_level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .clock_level_o   (clock_level_o),
    .busy_res_o      (busy_res_o),
    .reading_valid_o (reading_valid_o),
    .reading_value_o (reading_value_o),
    .average_valid_o (average_valid_o),
    .average_value_o (average_value_o),
    .timed_out_o     (timed_out_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // register copies
  logic [lcr_pkg::TIMEOUT_W-1:0] timeout_cfg = lcr_pkg::READY_TIMEOUT_RST;
  logic [lcr_pkg::COUNT_W-1:0]   avg_cfg     = lcr_pkg::AVERAGE_COUNT_RST;

  // reader state as seen from the ticks accepted so far
  seq_state_e                      rd_state  = ST_IDLE;
  logic [lcr_pkg::TIMEOUT_W-1:0]   wait_cnt  = '0;
  logic [lcr_pkg::BIT_CNT_W-1:0]   bit_cnt   = '0;
  logic [lcr_pkg::SAMPLE_BITS-1:0] shift_reg = '0;
  logic [lcr_pkg::SUM_W-1:0]       sum_acc   = '0;
  logic [lcr_pkg::COUNT_W-1:0]     done_cnt  = '0;
  logic                            tmo_seen  = 1'b0;

  lcr_pkg::lcr_item_t pending_ticks[$];
  tick_out_t          expected_words[$];
  logic      in_taken      = 1'b0;
  int        idle_pct      = IDLE_PCT;
  int        ticks_planned = 0;
  int        errors        = 0;
  int        quiet_cycles  = 0;
  bit        hold_armed    = 1'b0;
  bit        hold_used     = 1'b0;
  int        hold_left     = 0;

  // advance the reader by one tick and return the word it should produce
  function automatic tick_out_t reader_tick_out(input logic req, input logic level);
    tick_out_t                   r;
    logic                        fin;
    logic [lcr_pkg::SUM_W-1:0]   reading;
    logic [lcr_pkg::COUNT_W-1:0] cnt;
    int                          sum_s;
    int                          cnt_s;
    int                          quot;
    r       = '0;
    fin     = 1'b0;
    reading = '0;
    if (rd_state == ST_IDLE && req) begin
      sum_acc  = '0;
      done_cnt = '0;
      tmo_seen = 1'b0;
      wait_cnt = '0;
      rd_state = ST_WAIT_READY;
    end
    case (rd_state)
      ST_WAIT_READY: begin
        if (!level) begin
          bit_cnt   = '0;
          shift_reg = '0;
          r.sclk    = 1'b1;
          rd_state  = ST_CLK_HIGH;
        end else if (wait_cnt >= timeout_cfg) begin
          tmo_seen = 1'b1;
          fin      = 1'b1;
        end else begin
          wait_cnt = wait_cnt + 1'b1;
        end
      end
      ST_CLK_HIGH: begin
        shift_reg = {shift_reg[lcr_pkg::SAMPLE_BITS-2:0], level};
        bit_cnt   = bit_cnt + 1'b1;
        rd_state  = ST_CLK_LOW;
      end
      ST_CLK_LOW: begin
        r.sclk   = 1'b1;
        rd_state = (bit_cnt >= lcr_pkg::SAMPLE_BITS) ? ST_GAIN_HIGH : ST_CLK_HIGH;
      end
      ST_GAIN_HIGH: rd_state = ST_GAIN_LOW;
      ST_GAIN_LOW: begin
        reading = {{(lcr_pkg::SUM_W - lcr_pkg::SAMPLE_BITS)
                    {shift_reg[lcr_pkg::SAMPLE_BITS-1]}}, shift_reg};
        fin     = 1'b1;
      end
      default: rd_state = ST_IDLE;
    endcase
    // a finished reading goes into the sum; the last one closes the average
    if (fin) begin
      cnt      = (avg_cfg == '0) ? lcr_pkg::COUNT_W'(1) : avg_cfg;
      r.rd_vld = 1'b1;
      r.rd_val = reading[lcr_pkg::VALUE_W-1:0];
      sum_acc  = sum_acc + reading;
      done_cnt = done_cnt + 1'b1;
      wait_cnt = '0;
      if (done_cnt >= cnt) begin
        sum_s     = sum_acc;
        cnt_s     = cnt;
        quot      = sum_s / cnt_s;
        r.avg_vld = 1'b1;
        r.avg_val = quot[lcr_pkg::VALUE_W-1:0];
        rd_state  = ST_IDLE;
      end else begin
        rd_state = ST_WAIT_READY;
      end
    end
    r.busy = (rd_state != ST_IDLE);
    r.tmo  = tmo_seen;
    return r;
  endfunction

  task automatic report_word(input string what, input tick_out_t want, input tick_out_t got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("%0t %s: expected sclk=%0b busy=%0b rd=%0b/%0d avg=%0b/%0d tmo=%0b",
               $time, what, want.sclk, want.busy, want.rd_vld, $signed(want.rd_val),
               want.avg_vld, $signed(want.avg_val), want.tmo,
               "  got sclk=%0b busy=%0b rd=%0b/%0d avg=%0b/%0d tmo=%0b",
               got.sclk, got.busy, got.rd_vld, $signed(got.rd_val),
               got.avg_vld, $signed(got.avg_val), got.tmo);
  endtask

  // word accepted on the input: predict its result
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_words.push_back(reader_tick_out(read_request_i, data_level_i));
      void'(pending_ticks.pop_front());
    end
  end

  // driver: offer the next tick word, hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i     <= 1'b1;
        read_request_i <= pending_ticks[0].read_request;
        data_level_i   <= pending_ticks[0].data_level;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_armed && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    tick_out_t got;
    tick_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {clock_level_o, busy_res_o, reading_valid_o, reading_value_o,
             average_valid_o, average_value_o, timed_out_o};
      if (expected_words.size() == 0) begin
        report_word("unexpected word", '0, got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) report_word("mismatch", want, got);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [lcr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lcr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == lcr_pkg::CFG_READY_TIMEOUT) timeout_cfg = val[lcr_pkg::TIMEOUT_W-1:0];
    else avg_cfg = val[lcr_pkg::COUNT_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_tick(input logic req, input logic level);
    pending_ticks.push_back({req, level});
    ticks_planned++;
  endtask

  function automatic logic [lcr_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return lcr_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  // one reading: data line high for a while, then 24 bits and gain pulse; or high until timeout
  task automatic push_reading(input bit first, input bit to_timeout, input int hi_ticks,
                              input logic [lcr_pkg::VALUE_W-1:0] value);
    logic req;
    req = first;
    if (to_timeout) begin
      repeat (int'(timeout_cfg) + 1) begin
        push_tick(req, 1'b1);
        req = 1'($urandom_range(1));
      end
    end else begin
      repeat (hi_ticks) begin
        push_tick(req, 1'b1);
        req = 1'($urandom_range(1));
      end
      push_tick(req, 1'b0);
      for (int b = lcr_pkg::SAMPLE_BITS - 1; b >= 0; b--) begin
        push_tick(1'($urandom_range(1)), value[b]);
        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // whole averages with random content, optionally with stray ticks between them
  task automatic run_averages(input int n_avg, input bit noisy);
    int cnt;
    int hi_max;
    cnt    = (avg_cfg == '0) ? 1 : int'(avg_cfg);
    hi_max = (timeout_cfg < 6) ? int'(timeout_cfg) : 6;
    repeat (n_avg) begin
      repeat ($urandom_range(3)) push_tick(1'b0, 1'($urandom_range(1)));
      if (noisy && $urandom_range(4) == 0)
        repeat ($urandom_range(1, 3))
          push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      for (int r = 0; r < cnt; r++)
        push_reading(r == 0, timeout_cfg <= 8 && $urandom_range(3) == 0,
                     $urandom_range(hi_max), pick_value());
    end
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // power-on settings: idle ticks, then one plain reading
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    run_averages(1, 1'b0);
    drain();

    // immediate timeout, zero count acts as one, full-scale readings
    write_reg(lcr_pkg::CFG_READY_TIMEOUT, '0);
    write_reg(lcr_pkg::CFG_AVERAGE_COUNT, '0);
    push_reading(1'b1, 1'b1, 0, '0);
    push_reading(1'b1, 1'b1, 0, '0);
    push_reading(1'b1, 1'b0, 0, 24'h800000);
    push_reading(1'b1, 1'b0, 0, 24'h7FFFFF);
    drain();

    // short timeout, pairs of readings, receiver held off while ticks keep coming
    write_reg(lcr_pkg::CFG_READY_TIMEOUT, 20'd5);
    write_reg(lcr_pkg::CFG_AVERAGE_COUNT, 20'd2);
    hold_armed = 1'b1;
    run_averages(1, 1'b1);
    drain();

    // largest count: timeouts plus one negative full-scale reading
    write_reg(lcr_pkg::CFG_READY_TIMEOUT, '0);
    write_reg(lcr_pkg::CFG_AVERAGE_COUNT, 20'd255);
    for (int r = 0; r < 255; r++) push_reading(r == 0, r != 100, 0, 24'h800000);
    drain();

    // count lowered below the readings already done, mid-average
    write_reg(lcr_pkg::CFG_AVERAGE_COUNT, 20'd200);
    for (int r = 0; r < 20; r++) push_reading(r == 0, 1'b1, 0, '0);
    drain();
    write_reg(lcr_pkg::CFG_AVERAGE_COUNT, 20'd10);
    push_reading(1'b0, 1'b1, 0, '0);
    drain();

    // longest timeout, no idling on either side
    idle_pct = 0;
    write_reg(lcr_pkg::CFG_READY_TIMEOUT, 20'hFFFFF);
    write_reg(lcr_pkg::CFG_AVERAGE_COUNT, 20'd1);
    run_averages(1, 1'b1);
    drain();
    idle_pct = IDLE_PCT;

    // random settings, upper data bits of the count write are don't-care
    do begin
      write_reg(lcr_pkg::CFG_READY_TIMEOUT,
                $urandom_range(1) ? lcr_pkg::CFG_DATA_W'($urandom_range(8))
                                  : lcr_pkg::CFG_DATA_W'($urandom));
      write_reg(lcr_pkg::CFG_AVERAGE_COUNT, {12'($urandom), 8'($urandom_range(1, 2))});
      run_averages(1, 1'b1);
      drain();
    end while (ticks_planned < TICK_TARGET);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      errors++;
      $display("%0d expected words never arrived", expected_words.size());
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lcr_pkg.sv
design/lcr_front.sv
design/lcr_div.sv
design/lcr_back.sv
design/load_cell_adc_serial_reader_core.sv
sim/load_cell_adc_serial_reader_core_tb.sv
